// ===== rtl/core/kbxr_pkg.sv =====
`default_nettype none
package kbxr_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_REKEY   = 2'd0;
  localparam opcode_t OP_ENCRYPT = 2'd1;
  localparam opcode_t OP_DECRYPT = 2'd2;

  localparam int unsigned TW_N = 312;
  localparam int unsigned TW_M = 156;
  localparam int unsigned KEY_LEN = 256;

  localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] TW_SEED_MUL = 64'd6364136223846793005;
  localparam logic [7:0]  POS_MUL   = 8'h5D;

  // Output tempering of the 64-bit twister; only XORs of shifted copies.
  function automatic logic [63:0] temper(input logic [63:0] x_in);
    logic [63:0] x;
    x = x_in;
    x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
    x = x ^ ((x << 17) & 64'h71D6_7FFF_E000_0000);
    x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/keyed_byte_xor_rotate_cipher_unit.sv =====
// Keyed byte cipher. Requests enter on the in_ channel (in_opcode, in_data_in,
// in_last) with valid/ready; one result per request leaves on the out_
// channel (out_data_out, out_rekeyed). The 64-bit seed is written through the
// cfg_ channel, which is always ready; write it only while the block is idle.
// For an encrypt or decrypt request, the accept cycle reads the key byte at
// the current position from the key RAM, and S_CALC then forms the mask,
// transforms the byte and loads the output register once it is free. A new
// request can be taken in the cycle after the result is loaded, so a byte is
// not accepted while the one before it is still being transformed. A rekey
// request runs the 64-bit Mersenne twister over its 312-word RAM: seeding
// builds each word through one shared 32x32 multiplier, the refill reads each
// word and then writes it back, and the 256 key bytes are tempered and written
// during the refill. Opcode 3 returns a zero result and changes nothing.
// Reset (rst_n low, synchronous) clears the seed, the position, the output
// register and the key valid bits, so the key table reads as all zero until
// the first rekey. When the receiver stalls, the result waits in the output
// register; one more request may be accepted, and it then holds in the unit
// until the output register is free.
`default_nettype none
module keyed_byte_xor_rotate_cipher_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire kbxr_pkg::opcode_t     in_opcode,
  input  wire logic [7:0]            in_data_in,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_data_out,
  output logic                       out_rekeyed,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [63:0]           cfg_seed
);

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_SEED, S_RFL_RD, S_RFL_WR, S_DONE
  } state_t;

  state_t      state_r;
  logic [63:0] seed_r;
  logic [7:0]  pos_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_rekeyed_r;
  kbxr_pkg::opcode_t op_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic [8:0]  idx_r;
  logic [1:0]  ph_r;
  logic [63:0] prev_r;
  logic [63:0] acc_r;
  logic [63:0] cur_r;

  // Twister word RAM and key RAM.
  logic [63:0] tw_mem [kbxr_pkg::TW_N];
  logic [7:0]  key_mem [kbxr_pkg::KEY_LEN];
  logic [kbxr_pkg::KEY_LEN-1:0] key_vld_r;
  logic [63:0] rd1_r;
  logic [63:0] rd2_r;
  logic [7:0]  key_rd_r;
  logic        key_vld_rd_r;

  logic        out_free;
  logic        out_load;
  logic        accept;
  logic [63:0] seed_x;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] seed_word;
  logic        tw_we;
  logic [8:0]  tw_wa;
  logic [63:0] tw_wd;
  logic [8:0]  ra1;
  logic [8:0]  ra2;
  logic [63:0] y;
  logic [63:0] refill_v;
  logic [63:0] tempered;
  logic        key_we;
  logic [7:0]  key_byte;
  logic [15:0] pos_prod;
  logic [7:0]  mask;
  logic [15:0] rol_w;
  logic [15:0] ror_w;
  logic [7:0]  calc_out;

  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = out_free && (state_r == S_CALC || state_r == S_DONE);
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_rekeyed  = out_rekeyed_r;

  // Seeding: w[i] = C * (p ^ (p >> 62)) + i, low 64 bits, built from three
  // 32x32 partial products, one per seeding phase.
  assign seed_x = prev_r ^ (prev_r >> 62);
  always_comb begin
    case (ph_r)
      2'd0: begin
        mul_a = seed_x[31:0];
        mul_b = kbxr_pkg::TW_SEED_MUL[31:0];
      end
      2'd1: begin
        mul_a = seed_x[31:0];
        mul_b = kbxr_pkg::TW_SEED_MUL[63:32];
      end
      default: begin
        mul_a = seed_x[63:32];
        mul_b = kbxr_pkg::TW_SEED_MUL[31:0];
      end
    endcase
  end
  assign mul_p     = 64'(mul_a) * 64'(mul_b);
  assign seed_word = acc_r + {mul_p[31:0], 32'd0} + 64'(idx_r);

  // Refill step for word idx_r; the next word and the word M places on (mod N) come from the RAM.
  assign ra1 = (idx_r == 9'(kbxr_pkg::TW_N - 1)) ? 9'd0 : idx_r + 9'd1;
  assign ra2 = (idx_r >= 9'(kbxr_pkg::TW_N - kbxr_pkg::TW_M))
             ? idx_r - 9'(kbxr_pkg::TW_N - kbxr_pkg::TW_M)
             : idx_r + 9'(kbxr_pkg::TW_M);
  assign y = (cur_r & kbxr_pkg::TW_UPPER) | (rd1_r & kbxr_pkg::TW_LOWER);
  assign refill_v = rd2_r ^ (y >> 1) ^ (y[0] ? kbxr_pkg::TW_MATRIX : 64'd0);
  assign key_we   = (state_r == S_RFL_WR) && !idx_r[8];
  assign tempered = kbxr_pkg::temper(refill_v);
  assign key_byte = tempered[7:0];

  always_comb begin
    tw_we = 1'b0;
    tw_wa = idx_r;
    tw_wd = seed_word;
    if (accept && in_opcode == kbxr_pkg::OP_REKEY) begin
      tw_we = 1'b1;
      tw_wa = 9'd0;
      tw_wd = seed_r;
    end else if (state_r == S_SEED && ph_r == 2'd2) begin
      tw_we = 1'b1;
    end else if (state_r == S_RFL_WR) begin
      tw_we = 1'b1;
      tw_wd = refill_v;
    end
  end

  always_ff @(posedge clk) begin
    if (tw_we) begin
      tw_mem[tw_wa] <= tw_wd;
    end
    rd1_r <= tw_mem[ra1];
    rd2_r <= tw_mem[ra2];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[idx_r[7:0]] <= key_byte;
    end
    key_rd_r <= key_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r    <= '0;
      key_vld_rd_r <= 1'b0;
    end else begin
      if (key_we) begin
        key_vld_r[idx_r[7:0]] <= 1'b1;
      end
      key_vld_rd_r <= key_vld_r[pos_r];
    end
  end

  // Byte transform.
  assign pos_prod = 16'(pos_r) * 16'(kbxr_pkg::POS_MUL);
  assign mask = (key_vld_rd_r ? key_rd_r : 8'd0) ^ pos_prod[7:0]
              ^ 8'(seed_r[14:0] >> pos_r[2:0]);
  assign rol_w = {data_r ^ mask, data_r ^ mask} << pos_r[2:0];
  assign ror_w = {data_r, data_r} >> pos_r[2:0];
  always_comb begin
    case (op_r)
      kbxr_pkg::OP_ENCRYPT: calc_out = rol_w[15:8];
      kbxr_pkg::OP_DECRYPT: calc_out = ror_w[7:0] ^ mask;
      default:              calc_out = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      seed_r        <= '0;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
      out_data_r    <= '0;
      out_rekeyed_r <= 1'b0;
      idx_r         <= '0;
      ph_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_seed;
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r   <= in_opcode;
            data_r <= in_data_in;
            last_r <= in_last;
            if (in_opcode == kbxr_pkg::OP_REKEY) begin
              prev_r  <= seed_r;
              idx_r   <= 9'd1;
              ph_r    <= 2'd0;
              state_r <= S_SEED;
            end else begin
              state_r <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_data_r    <= calc_out;
            out_rekeyed_r <= 1'b0;
            if (op_r == kbxr_pkg::OP_ENCRYPT || op_r == kbxr_pkg::OP_DECRYPT) begin
              pos_r <= last_r ? 8'd0 : pos_r + 8'd1;
            end
            state_r <= S_IDLE;
          end
        end
        S_SEED: begin
          case (ph_r)
            2'd0: begin
              acc_r <= mul_p;
              ph_r  <= 2'd1;
            end
            2'd1: begin
              acc_r <= acc_r + {mul_p[31:0], 32'd0};
              ph_r  <= 2'd2;
            end
            default: begin
              prev_r <= seed_word;
              ph_r   <= 2'd0;
              if (idx_r == 9'(kbxr_pkg::TW_N - 1)) begin
                idx_r   <= 9'd0;
                cur_r   <= seed_r;
                state_r <= S_RFL_RD;
              end else begin
                idx_r <= idx_r + 9'd1;
              end
            end
          endcase
        end
        S_RFL_RD: begin
          state_r <= S_RFL_WR;
        end
        S_RFL_WR: begin
          cur_r <= rd1_r;
          if (idx_r == 9'(kbxr_pkg::TW_N - 1)) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 9'd1;
            state_r <= S_RFL_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_data_r    <= 8'd0;
            out_rekeyed_r <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kbxr_checker.sv =====
`default_nettype none
module kbxr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data_out,
  input wire logic       out_rekeyed
);

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out) && $stable(out_rekeyed))
    else $error("result changed while stalled");

  // A rekey answer carries a zero byte.
  a_rekey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rekeyed |-> out_data_out == 8'd0)
    else $error("rekey result has nonzero data");

  // The unit works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyed_byte_xor_rotate_cipher_unit kbxr_checker u_kbxr_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data_out(out_data_out),
  .out_rekeyed(out_rekeyed)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 has no meaning in the block; it must return a zero result.
  localparam kbxr_pkg::opcode_t OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  kbxr_pkg::opcode_t in_opcode = kbxr_pkg::OP_ENCRYPT;
  logic [7:0]  in_data_in = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data_out;
  logic        out_rekeyed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_seed = 64'd0;

  keyed_byte_xor_rotate_cipher_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_data_in(in_data_in), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data_out(out_data_out), .out_rekeyed(out_rekeyed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_seed(cfg_seed)
  );

  always #10 clk = ~clk;

  // Shadow copy of the cipher state that the predictor works on.
  logic [63:0] seed_reg;
  logic [7:0]  key_table [0:255];
  logic [63:0] twister [0:311];
  logic [7:0]  byte_pos;

  typedef struct packed {
    logic [7:0] data_out;
    logic       rekeyed;
  } cipher_result_t;

  cipher_result_t pending_results[$];
  int  fail_count = 0;
  bit  steady_flow = 1'b0;  // when set, neither side idles

  // Key table generation: seed the 64-bit twister, refill once, keep the
  // low byte of each of the first 256 tempered words.
  task automatic regenerate_key_table();
    logic [63:0] p, y, v, x;
    for (int i = 0; i < 312; i++) begin
      if (i == 0) begin
        twister[0] = seed_reg;
      end else begin
        p = twister[i - 1];
        twister[i] = 64'd6364136223846793005 * (p ^ (p >> 62)) + 64'(i);
      end
    end
    for (int i = 0; i < 312; i++) begin
      y = (twister[i] & 64'hFFFF_FFFF_8000_0000) |
          (twister[(i + 1) % 312] & 64'h0000_0000_7FFF_FFFF);
      v = twister[(i + 156) % 312] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ 64'hB502_6F5A_A966_19E9;
      end
      twister[i] = v;
    end
    for (int i = 0; i < 256; i++) begin
      x = twister[i];
      x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
      x = x ^ ((x << 17) & 64'h71D6_7FFF_E000_0000);
      x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
      x = x ^ (x >> 43);
      key_table[i] = x[7:0];
    end
  endtask

  // The per-position mask combines the key byte, the position times 0x5D
  // and the seed shifted by the position mod 8.
  function automatic logic [7:0] position_mask(logic [7:0] pos);
    logic [15:0] prod;
    logic [63:0] shifted;
    prod = 16'(pos) * 16'h5D;
    shifted = seed_reg >> pos[2:0];
    return key_table[pos] ^ prod[7:0] ^ shifted[7:0];
  endfunction

  task automatic predict_cipher_result(kbxr_pkg::opcode_t op, logic [7:0] din, logic lst);
    cipher_result_t r;
    logic [7:0] t;
    logic [2:0] s;
    r = '0;
    s = byte_pos[2:0];
    if (op == kbxr_pkg::OP_REKEY) begin
      regenerate_key_table();
      r.rekeyed = 1'b1;
    end else if (op == kbxr_pkg::OP_ENCRYPT || op == kbxr_pkg::OP_DECRYPT) begin
      if (op == kbxr_pkg::OP_ENCRYPT) begin
        t = din ^ position_mask(byte_pos);
        r.data_out = (s == 0) ? t : 8'((t << s) | (t >> (4'd8 - s)));
      end else begin
        t = (s == 0) ? din : 8'((din >> s) | (din << (4'd8 - s)));
        r.data_out = t ^ position_mask(byte_pos);
      end
      byte_pos = lst ? 8'd0 : byte_pos + 8'd1;
    end
    pending_results.push_back(r);
  endtask

  // Sends one request, idling at random beforehand unless steady_flow is set,
  // and records its expected result at the moment of acceptance. Valid stays
  // high after acceptance; it drops when the sender idles or waits.
  task automatic send_request(kbxr_pkg::opcode_t op, logic [7:0] din, logic lst);
    if (!steady_flow && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < 15);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_data_in <= din;
    in_last    <= lst;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_cipher_result(op, din, lst);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  // Seed writes happen only with the block idle.
  task automatic write_seed(logic [63:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    seed_reg = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver side: random back-pressure and the result comparison.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: data_out %0h rekeyed %0b", out_data_out, out_rekeyed);
          fail_count++;
        end else begin
          cipher_result_t e;
          e = pending_results.pop_front();
          if (out_data_out !== e.data_out) begin
            $error("data_out expected %0h actual %0h", e.data_out, out_data_out);
            fail_count++;
          end
          if (out_rekeyed !== e.rekeyed) begin
            $error("rekeyed expected %0b actual %0b", e.rekeyed, out_rekeyed);
            fail_count++;
          end
        end
      end
      out_ready <= steady_flow || ($urandom_range(99) >= 15);
    end
  end

  // Encryption and decryption with the all-zero key table, both field extremes,
  // the unused opcode and a buffer end.
  task automatic test_directed_before_rekey();
    send_request(kbxr_pkg::OP_ENCRYPT, 8'h00, 1'b0);
    send_request(kbxr_pkg::OP_ENCRYPT, 8'hFF, 1'b0);
    send_request(kbxr_pkg::OP_DECRYPT, 8'hFF, 1'b0);
    send_request(kbxr_pkg::OP_DECRYPT, 8'h00, 1'b0);
    send_request(OP_UNUSED, 8'hA5, 1'b1);
    send_request(kbxr_pkg::OP_ENCRYPT, 8'h5A, 1'b1);
    send_request(kbxr_pkg::OP_ENCRYPT, 8'h5A, 1'b0);
  endtask

  // Rekey with zero and all-ones seeds; last on a rekey must be ignored,
  // and changing the seed afterwards keeps the old key table.
  task automatic test_directed_rekey();
    send_request(kbxr_pkg::OP_REKEY, 8'hFF, 1'b1);
    send_request(kbxr_pkg::OP_ENCRYPT, 8'h3C, 1'b0);
    send_request(kbxr_pkg::OP_DECRYPT, 8'hC3, 1'b1);
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_request(kbxr_pkg::OP_ENCRYPT, 8'h81, 1'b0);
    send_request(kbxr_pkg::OP_REKEY, 8'h00, 1'b0);
    send_request(kbxr_pkg::OP_DECRYPT, 8'h7E, 1'b0);
    send_request(OP_UNUSED, 8'h00, 1'b0);
  endtask

  // A long run without last walks the position through its wrap.
  task automatic test_position_wrap();
    write_seed(64'h0123_4567_89AB_CDEF);
    send_request(kbxr_pkg::OP_REKEY, 8'h00, 1'b0);
    for (int i = 0; i < 300; i++) begin
      send_request($urandom_range(1) ? kbxr_pkg::OP_ENCRYPT : kbxr_pkg::OP_DECRYPT,
                   8'($urandom), 1'b0);
    end
  endtask

  // Random buffers under random seeds; rekeys and the unused opcode are
  // mixed in rarely. One phase runs with no idling at all.
  task automatic test_random_buffers();
    kbxr_pkg::opcode_t op;
    int n;
    n = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_seed({$urandom, $urandom});
      steady_flow = (phase == 2);
      send_request(kbxr_pkg::OP_REKEY, 8'($urandom), 1'($urandom));
      for (int i = 0; i < 100; i++) begin
        n = $urandom_range(99);
        if (n < 2) begin
          op = kbxr_pkg::OP_REKEY;
        end else if (n < 5) begin
          op = OP_UNUSED;
        end else begin
          op = (n & 1) ? kbxr_pkg::OP_ENCRYPT : kbxr_pkg::OP_DECRYPT;
        end
        send_request(op, 8'($urandom), $urandom_range(19) == 0);
      end
      steady_flow = 1'b0;
      // Hold off the sender until everything outstanding has come back.
      in_valid <= 1'b0;
      while (pending_results.size() != 0) begin
        @(posedge clk);
      end
    end
  endtask

  initial begin
    seed_reg = 64'd0;
    byte_pos = 8'd0;
    foreach (key_table[i]) key_table[i] = 8'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_before_rekey();
    test_directed_rekey();
    test_position_wrap();
    test_random_buffers();
    drain_results();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Room for about 20 rekeys plus ~1000 bytes with stalls.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
